/* src/spi_pkg.sv */
// Shared types and widths for the segment/plane intersection pipeline.
// No dependencies; imported by every module in src.
package spi_pkg;

	localparam int QW = 32;          // Q16.16 word
	localparam int FW = 16;          // fraction bits
	localparam int MW = 51;          // magnitude width of num and den
	localparam int RW = MW + 1;      // divider remainder width
	localparam int SW = 52;          // signed width of den and num sums
	localparam int DIV_STAGES = QW;  // one quotient bit per stage

	localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	typedef logic [2:0][QW-1:0] vec_t;

	// Item state while the quotient is being formed.
	typedef struct packed {
		vec_t            b;
		vec_t            dv;
		logic            clip;
		logic            nz;
		logic            neg;
		logic            ovf;
		logic [MW-1:0]   dmag;
		logic [FW-1:0]   nlo;
		logic [RW-1:0]   rem;
		logic [QW-1:0]   q;
	} div_t;

endpackage

/* src/segment_plane_intersection.sv */
// Segment/plane intersection, signed Q16.16, fully pipelined.
// Order from input transfer to result: front stages, quotient pipeline, back stages.
// Throughput: one segment per cycle while out_stall is low; the 32-stage quotient pipeline sets the depth.
// Bubbles collapse: each stage advances when the stage ahead is empty or moving.
// Reset (arst_n low) clears all valid bits and the plane registers to zero.
module segment_plane_intersection import spi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_index,
	input  logic [QW-1:0]  cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [QW-1:0]  start_x,
	input  logic [QW-1:0]  start_y,
	input  logic [QW-1:0]  start_z,
	input  logic [QW-1:0]  end_x,
	input  logic [QW-1:0]  end_y,
	input  logic [QW-1:0]  end_z,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [QW-1:0]  hit_x,
	output logic [QW-1:0]  hit_y,
	output logic [QW-1:0]  hit_z,
	output logic           hit_valid,
	output logic           clipped
);

	localparam logic [1:0] REG_NX = 2'd0;
	localparam logic [1:0] REG_NY = 2'd1;
	localparam logic [1:0] REG_NZ = 2'd2;
	localparam logic [1:0] REG_D  = 2'd3;

	// Plane coefficients; the user must write them only while the pipe is idle; the block does not enforce this.
	vec_t norm_q;
	logic [QW-1:0] offset_q;

	vec_t a_in, b_in;
	logic f_valid, f_stall, d_valid, d_stall;
	div_t f_item, d_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q   <= '0;
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NX:  norm_q[0] <= cfg_data;
				REG_NY:  norm_q[1] <= cfg_data;
				REG_NZ:  norm_q[2] <= cfg_data;
				REG_D:   offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign a_in = {start_z, start_y, start_x};
	assign b_in = {end_z, end_y, end_x};

	// Differences, dot products n.D and n.B + d, then divider setup.
	spi_front u_front (
		.clk(clk), .arst_n(arst_n), .norm(norm_q), .offset(offset_q),
		.in_valid(in_valid), .in_stall(in_stall), .a(a_in), .b(b_in),
		.out_valid(f_valid), .out_stall(f_stall), .out_item(f_item)
	);

	// t = |num| * 2^16 / |den|, one bit per stage.
	spi_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_stall(f_stall), .in_item(f_item),
		.out_valid(d_valid), .out_stall(d_stall), .out_item(d_item)
	);

	// Sign and saturate t, form B + t*D, hold result in the output register.
	spi_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(d_valid), .in_stall(d_stall), .in_item(d_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.hit_valid(hit_valid), .clipped(clipped)
	);

`ifndef SYNTH
	// A parallel line reports the origin.
	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_valid |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
		else $error("parallel result has nonzero coordinates");
	// The input side only stalls when the whole pipe is full and blocked.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && f_valid && d_valid)
		else $error("input stalled with room in the pipe");
	// An empty output register never backs up the input.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !d_stall)
		else $error("back end stalled while output empty");
`endif

endmodule

/* src/spi_front.sv */
// Front stages: differences, dot products, magnitudes and divider setup.
// Depends on spi_pkg.
module spi_front import spi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vec_t                 norm,
	input  logic [QW-1:0]        offset,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  vec_t                 a,
	input  vec_t                 b,
	output logic                 out_valid,
	input  logic                 out_stall,
	output div_t                 out_item
);

	logic [4:1] v;
	logic [5:1] go;
	vec_t b_s1, dv_s1, b_s2, dv_s2;
	logic clip_s1, clip_s2, clip_s3;
	vec_t b_s3, dv_s3;
	logic [2:0][63:0] pnd_s2, pnb_s2;
	logic signed [SW-1:0] den_s3, num_s3;
	logic signed [SW-1:0] den_c, num_c, numn;
	logic [MW-1:0] nmag, dmag;
	vec_t dv_c;
	logic clip_c;
	div_t item_s4;

	assign go[5] = !out_stall;
	genvar g;
	generate
		for (g = 1; g <= 4; g++) begin : g_go
			assign go[g] = !v[g] || go[g+1];
		end
	endgenerate
	assign in_stall = !go[1];

	always_comb begin
		logic signed [QW:0] d;
		clip_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d = $signed({a[i][QW-1], a[i]}) - $signed({b[i][QW-1], b[i]});
			if (d[QW] != d[QW-1]) begin
				clip_c = 1'b1;
				dv_c[i] = d[QW] ? Q_MIN : Q_MAX;
			end else begin
				dv_c[i] = d[QW-1:0];
			end
		end
	end

	always_comb begin
		den_c = '0;
		num_c = SW'($signed(offset));
		for (int i = 0; i < 3; i++) begin
			den_c = den_c + SW'($signed(pnd_s2[i][63:FW]));
			num_c = num_c + SW'($signed(pnb_s2[i][63:FW]));
		end
	end

	always_comb begin
		numn = -num_s3;
		nmag = numn[SW-1] ? MW'(-numn) : numn[MW-1:0];
		dmag = den_s3[SW-1] ? MW'(-den_s3) : den_s3[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (go[1]) v[1] <= in_valid;
			if (go[2]) v[2] <= v[1];
			if (go[3]) v[3] <= v[2];
			if (go[4]) v[4] <= v[3];
		end
	end

	always_ff @(posedge clk) begin
		if (go[1]) begin
			b_s1    <= b;
			dv_s1   <= dv_c;
			clip_s1 <= clip_c;
		end
		if (go[2]) begin
			b_s2    <= b_s1;
			dv_s2   <= dv_s1;
			clip_s2 <= clip_s1;
			for (int i = 0; i < 3; i++) begin
				pnd_s2[i] <= 64'($signed(norm[i]) * $signed(dv_s1[i]));
				pnb_s2[i] <= 64'($signed(norm[i]) * $signed(b_s1[i]));
			end
		end
		if (go[3]) begin
			b_s3    <= b_s2;
			dv_s3   <= dv_s2;
			clip_s3 <= clip_s2;
			den_s3  <= den_c;
			num_s3  <= num_c;
		end
		if (go[4]) begin
			item_s4.b    <= b_s3;
			item_s4.dv   <= dv_s3;
			item_s4.clip <= clip_s3;
			item_s4.nz   <= den_s3 != '0;
			item_s4.neg  <= numn[SW-1] ^ den_s3[SW-1];
			item_s4.ovf  <= MW'(nmag[MW-1:FW]) >= dmag;
			item_s4.dmag <= dmag;
			item_s4.nlo  <= nmag[FW-1:0];
			item_s4.rem  <= RW'(nmag[MW-1:FW]);
			item_s4.q    <= '0;
		end
	end

	assign out_valid = v[4];
	assign out_item  = item_s4;

endmodule

/* src/spi_div.sv */
// Pipelined restoring divider: one quotient bit per stage, msb first.
// Depends on spi_pkg.
module spi_div import spi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  div_t  in_item,
	output logic  out_valid,
	input  logic  out_stall,
	output div_t  out_item
);

	div_t st_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] v;
	logic [DIV_STAGES:0] go;

	assign go[DIV_STAGES] = !out_stall;

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_st
			localparam int K = DIV_STAGES - 1 - g;
			div_t prev, nxt;
			logic pv;
			logic [RW-1:0] rem2;
			logic bitin;
			if (g == 0) begin : g_first
				assign prev = in_item;
				assign pv   = in_valid;
			end else begin : g_rest
				assign prev = st_s[g-1];
				assign pv   = v[g-1];
			end
			assign go[g] = !v[g] || go[g+1];
			always_comb begin
				bitin = (K >= FW) ? prev.nlo[(K >= FW) ? K - FW : 0] : 1'b0;
				rem2  = {prev.rem[RW-2:0], bitin};
				nxt   = prev;
				if (rem2 >= {1'b0, prev.dmag}) begin
					nxt.rem  = rem2 - {1'b0, prev.dmag};
					nxt.q[K] = 1'b1;
				end else begin
					nxt.rem = rem2;
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v[g] <= 1'b0;
				else if (go[g]) v[g] <= pv;
			end
			always_ff @(posedge clk) begin
				if (go[g]) st_s[g] <= nxt;
			end
		end
	endgenerate

	assign in_stall  = !go[0];
	assign out_valid = v[DIV_STAGES-1];
	assign out_item  = st_s[DIV_STAGES-1];

endmodule

/* src/spi_back.sv */
// Back stages: saturate t, scale the direction, add the end point.
// Depends on spi_pkg.
module spi_back import spi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  div_t           in_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [QW-1:0]  hit_x,
	output logic [QW-1:0]  hit_y,
	output logic [QW-1:0]  hit_z,
	output logic           hit_valid,
	output logic           clipped
);

	logic [3:1] v;
	logic [4:1] go;
	logic [QW-1:0] t_c, t_s1;
	logic tclip_c;
	vec_t b_s1, dv_s1, b_s2;
	logic clip_s1, nz_s1, clip_s2, nz_s2;
	logic [2:0][63:0] p_s2;
	vec_t hit_c;
	logic hclip_c;
	vec_t hit_s3;
	logic nz_s3, clip_s3;

	assign go[4] = !out_stall;
	genvar g;
	generate
		for (g = 1; g <= 3; g++) begin : g_go
			assign go[g] = !v[g] || go[g+1];
		end
	endgenerate
	assign in_stall = !go[1];

	always_comb begin
		tclip_c = 1'b0;
		if (in_item.neg) begin
			if (in_item.ovf || in_item.q > Q_MIN) begin
				tclip_c = 1'b1;
				t_c = Q_MIN;
			end else begin
				t_c = -in_item.q;
			end
		end else begin
			if (in_item.ovf || in_item.q > Q_MAX) begin
				tclip_c = 1'b1;
				t_c = Q_MAX;
			end else begin
				t_c = in_item.q;
			end
		end
	end

	always_comb begin
		logic signed [48:0] s;
		hclip_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			s = 49'($signed(b_s2[i])) + 49'($signed(p_s2[i][63:FW]));
			if (s > 49'($signed(Q_MAX))) begin
				hclip_c = 1'b1;
				hit_c[i] = Q_MAX;
			end else if (s < 49'($signed(Q_MIN))) begin
				hclip_c = 1'b1;
				hit_c[i] = Q_MIN;
			end else begin
				hit_c[i] = s[QW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (go[1]) v[1] <= in_valid;
			if (go[2]) v[2] <= v[1];
			if (go[3]) v[3] <= v[2];
		end
	end

	always_ff @(posedge clk) begin
		if (go[1]) begin
			t_s1    <= t_c;
			b_s1    <= in_item.b;
			dv_s1   <= in_item.dv;
			nz_s1   <= in_item.nz;
			clip_s1 <= in_item.clip || (in_item.nz && tclip_c);
		end
		if (go[2]) begin
			b_s2    <= b_s1;
			nz_s2   <= nz_s1;
			clip_s2 <= clip_s1;
			for (int i = 0; i < 3; i++)
				p_s2[i] <= 64'($signed(t_s1) * $signed(dv_s1[i]));
		end
		if (go[3]) begin
			hit_s3  <= nz_s2 ? hit_c : '0;
			nz_s3   <= nz_s2;
			clip_s3 <= clip_s2 || (nz_s2 && hclip_c);
		end
	end

	assign out_valid = v[3];
	assign hit_x     = hit_s3[0];
	assign hit_y     = hit_s3[1];
	assign hit_z     = hit_s3[2];
	assign hit_valid = nz_s3;
	assign clipped   = clip_s3;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for segment_plane_intersection.
// Depends on spi_pkg and the block's RTL; predicts each hit point in
// 64-bit integer arithmetic and compares every result transfer in order.
`timescale 1ns / 1ps

module testbench;
	import spi_pkg::*;

	// One result transfer as the block presents it.
	typedef struct {
		logic [QW-1:0] x, y, z;
		logic          hv, clip;
	} hit_t;

	// Holds the plane copy, computes expected hits, checks them in order.
	class hit_scoreboard;
		longint   plane[4];
		hit_t     pending_hits[$];
		int       errors;

		function new();
			foreach (plane[i]) plane[i] = 0;
			errors = 0;
		endfunction

		function void set_plane(int idx, logic [QW-1:0] val);
			plane[idx] = longint'($signed(val));
		endfunction

		function automatic longint sat_q(longint v, inout bit c);
			if (v > 64'sd2147483647) begin
				c = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				c = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// Compute the intersection for one accepted segment and queue it.
		function automatic void record_segment(vec_t a_pt, vec_t b_pt);
			longint   bq[3], dq[3], den, num, t;
			logic [63:0] q, nmag, dmag;
			bit       c, neg;
			hit_t     h;
			c = 0;
			den = 0;
			num = 0;
			for (int i = 0; i < 3; i++) begin
				bq[i] = longint'($signed(b_pt[i]));
				dq[i] = sat_q(longint'($signed(a_pt[i])) - bq[i], c);
				den += (plane[i] * dq[i]) >>> FW;
				num += (plane[i] * bq[i]) >>> FW;
			end
			num = -(num + plane[3]);
			h.clip = 0;
			if (den == 0) begin
				h.x = '0;
				h.y = '0;
				h.z = '0;
				h.hv = 0;
				h.clip = c;
			end else begin
				nmag = (num < 0) ? -num : num;
				dmag = (den < 0) ? -den : den;
				q = (nmag << FW) / dmag;
				neg = (num < 0) != (den < 0);
				if (neg) begin
					if (q > 64'd2147483648) begin
						c = 1;
						t = -64'sd2147483648;
					end else t = -longint'(q);
				end else begin
					if (q > 64'd2147483647) begin
						c = 1;
						t = 64'sd2147483647;
					end else t = longint'(q);
				end
				h.x = QW'(sat_q(bq[0] + ((t * dq[0]) >>> FW), c));
				h.y = QW'(sat_q(bq[1] + ((t * dq[1]) >>> FW), c));
				h.z = QW'(sat_q(bq[2] + ((t * dq[2]) >>> FW), c));
				h.hv = 1;
				h.clip = c;
			end
			pending_hits.push_back(h);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		// Compare one result transfer with the oldest expected hit.
		task compare_hit(hit_t got);
			hit_t want;
			if (pending_hits.size() == 0) begin
				report("unexpected result", 64'(got.x), 64'd0);
				return;
			end
			want = pending_hits.pop_front();
			if (got.x !== want.x) report("hit_x", 64'(got.x), 64'(want.x));
			if (got.y !== want.y) report("hit_y", 64'(got.y), 64'(want.y));
			if (got.z !== want.z) report("hit_z", 64'(got.z), 64'(want.z));
			if (got.hv !== want.hv) report("hit_valid", 64'(got.hv), 64'(want.hv));
			if (got.clip !== want.clip) report("clipped", 64'(got.clip), 64'(want.clip));
		endtask
	endclass

	localparam logic [QW-1:0] ZERO = '0;
	localparam logic [QW-1:0] ONE = 32'h0001_0000;
	localparam int DRAIN_CYCLES = 60;   // longer than the pipeline latency

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_wr_en = 0;
	logic [1:0]    cfg_index = '0;
	logic [QW-1:0] cfg_data = '0;
	logic          in_valid = 0;
	logic          in_stall;
	logic [QW-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic [QW-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic          out_valid;
	logic          out_stall = 0;
	logic [QW-1:0] hit_x, hit_y, hit_z;
	logic          hit_valid, clipped;

	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            hold_cycles = 0;
	hit_scoreboard sb = new();

	segment_plane_intersection dut (.*);

	always #10 clk = ~clk;

	// Receiver: stall at random, or hold off for a counted stretch.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Note each input transfer; values are the ones held before this edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.record_segment({start_z, start_y, start_x}, {end_z, end_y, end_x});
	end

	// Check each result transfer.
	always @(posedge clk) begin
		hit_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.x = hit_x;
			r.y = hit_y;
			r.z = hit_z;
			r.hv = hit_valid;
			r.clip = clipped;
			sb.compare_hit(r);
		end
	end

	// Offer one segment; keep valid high across back-to-back transfers.
	task send_segment(vec_t a_pt, vec_t b_pt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{start_z, start_y, start_x} <= a_pt;
		{end_z, end_y, end_x} <= b_pt;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, drain every expected hit, then let the pipe settle.
	task drain;
		in_valid <= 0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_plane(logic [QW-1:0] nx, logic [QW-1:0] ny, logic [QW-1:0] nz,
			logic [QW-1:0] d);
		logic [QW-1:0] vals[4];
		vals = '{nx, ny, nz, d};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			sb.set_plane(i, vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	// Mostly moderate coordinates so hits land in range, with extremes mixed in.
	function automatic logic [QW-1:0] rand_q();
		case ($urandom_range(9))
			0: return Q_MIN;
			1: return Q_MAX;
			2, 3: return $urandom;
			default: return QW'($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	function automatic vec_t rand_vec();
		return {rand_q(), rand_q(), rand_q()};
	endfunction

	initial begin
		vec_t p, q;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero plane at reset means every line is parallel.
		send_segment({Q_MAX, Q_MIN, ONE}, {Q_MIN, Q_MAX, ZERO});
		send_segment('0, '0);
		drain();

		// Plane x = 1: plain hit, extreme coordinates, difference overflow.
		write_plane(ONE, '0, '0, -ONE);
		send_segment({3 * ONE, 2 * ONE, 2 * ONE}, {ONE, ZERO, ZERO});
		send_segment({ZERO, ZERO, Q_MAX}, {ZERO, ZERO, Q_MIN});
		send_segment({Q_MIN, Q_MAX, Q_MIN}, {Q_MAX, Q_MIN, Q_MAX});
		send_segment({ZERO, ZERO, ONE + 1}, {ZERO, ZERO, ONE - 1});
		// Plane off the segment: t = 2, so the hit lies past A.
		send_segment({5 * ONE, 5 * ONE, 32'd1}, {5 * ONE, 5 * ONE, 32'hFFFF_0000 + 32'd2});
		// Parallel to plane: A and B share x.
		send_segment({ONE, 7 * ONE, 2 * ONE}, {-ONE, -ONE, 2 * ONE});
		drain();

		// Extreme planes: all coefficients at the top, then at the bottom.
		write_plane(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_segment({Q_MAX, Q_MAX, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN});
		send_segment({ONE, ONE, ONE}, {ZERO, ZERO, ZERO});
		send_segment({Q_MIN, ZERO, Q_MAX}, {Q_MAX, ZERO, Q_MIN});
		drain();
		write_plane(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_segment({Q_MAX, Q_MAX, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN});
		send_segment({ONE, -ONE, ONE}, {ZERO, ONE, ZERO});
		send_segment({ZERO, ZERO, ZERO}, {Q_MIN, Q_MIN, Q_MIN});
		drain();

		// Random phases: new plane each phase, idling by phase pair.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_plane(Q_MAX, '0, Q_MIN, Q_MAX);
				1: write_plane('0, ONE, '0, '0);
				5: write_plane('0, '0, '0, $urandom);
				default: write_plane(rand_q(), rand_q(), rand_q(), rand_q());
			endcase
			send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 73 : 0;
			recv_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 21 : 0;
			// Long hold-off so the pipeline fills and backs up the input.
			if (ph == 4) hold_cycles <= 300;
			for (int k = 0; k < 125; k++) begin
				p = rand_vec();
				q = rand_vec();
				send_segment(p, q);
			end
			drain();
		end

		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
src/spi_pkg.sv
src/spi_front.sv
src/spi_div.sv
src/spi_back.sv
src/segment_plane_intersection.sv
tb/sv/testbench.sv
